@@ hw/rtl/sle_pkg.sv @@
package sle_pkg;

  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 1;

  // received characters with special meaning
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MODE = 1'd1;

  localparam logic [7:0] CAP_RESET = 8'd255;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_char;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;
  } out_item_t;

  // everything the emitter needs to produce the results of one input
  typedef struct packed {
    logic       kind;
    logic [1:0] nres;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       done;
    logic [7:0] len;
    logic       hit;
  } plan_t;

endpackage

@@ hw/rtl/sle_ram.sv @@
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sle_front.sv @@
module sle_front
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 accept,
  input  in_item_t             item,
  output plan_t                plan,
  output logic                 plan_valid,
  output logic [7:0]           rdata
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [7:0]    cap_r;
  logic          word_r;
  logic [AW-1:0] count_r, count_nxt;
  logic          complete_r, complete_nxt;

  logic [AW-1:0] cnt_eff;
  logic [8:0]    cap9, lim9, inc9;
  logic          ram_we, ram_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      word_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:  cap_r  <= cfg_wdata;
        CFG_WORD_MODE: word_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // held limit: capacity clamped to two, minus one, capped by the store
  always_comb begin
    cap9 = (cap_r < 8'd2) ? 9'd2 : {1'b0, cap_r};
    lim9 = cap9 - 9'd1;
    if (lim9 > 9'(LINE_DEPTH - 1)) begin
      lim9 = 9'(LINE_DEPTH - 1);
    end
  end

  always_comb begin
    cnt_eff      = complete_r ? '0 : count_r;
    inc9         = 9'(cnt_eff) + 9'd1;
    count_nxt    = cnt_eff;
    complete_nxt = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    plan         = '0;
    plan.kind    = KIND_ECHO;
    plan.nres    = 2'd1;
    plan.b0      = item.rx_char;

    if (item.opcode == OP_READ) begin
      count_nxt    = count_r;
      complete_nxt = complete_r;
      ram_re       = 1'b1;
      plan.kind    = KIND_READ;
      plan.hit     = item.read_index < 8'(count_r);
    end else begin
      case (item.rx_char)
        CH_BS: begin
          if (cnt_eff == '0) begin
            plan.nres = 2'd0;
          end else begin
            count_nxt = cnt_eff - AW'(1);
            plan.nres = 2'd3;
            plan.b0   = CH_BS;
            plan.b1   = CH_SP;
            plan.b2   = CH_BS;
          end
        end
        CH_CR: begin
          complete_nxt = 1'b1;
          plan.nres    = 2'd2;
          plan.b0      = CH_CR;
          plan.b1      = CH_LF;
          plan.done    = 1'b1;
        end
        CH_LF: begin
          complete_nxt = 1'b1;
          plan.nres    = 2'd2;
          plan.b0      = CH_LF;
          plan.b1      = CH_CR;
          plan.done    = 1'b1;
        end
        default: begin
          if (word_r && item.rx_char == CH_SP) begin
            complete_nxt = 1'b1;
            plan.done    = 1'b1;
          end else begin
            ram_we       = 1'b1;
            count_nxt    = inc9[AW-1:0];
            complete_nxt = inc9 >= lim9;
            plan.done    = complete_nxt;
          end
        end
      endcase
    end
    plan.len   = 8'(count_nxt);
    plan_valid = plan.nres != 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      complete_r <= 1'b0;
    end else if (accept) begin
      count_r    <= count_nxt;
      complete_r <= complete_nxt;
    end
  end

  sle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (accept && ram_we),
    .waddr   (cnt_eff),
    .wdata   (item.rx_char),
    .re      (accept && ram_re),
    .raddr   (item.read_index[AW-1:0]),
    .rdata_r (rdata)
  );

endmodule

@@ hw/rtl/sle_emit.sv @@
module sle_emit
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  plan_t      plan,
  input  logic       plan_valid,
  input  logic       accept,
  input  logic [7:0] rdata,
  output logic       take_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  plan_t      plan_r;
  logic       p_valid_r, p_valid_nxt;
  logic [1:0] step_r, step_nxt;
  out_item_t  out_r, res;
  logic       o_valid_r;

  logic o_free, p_fire, p_last, p_end;

  assign o_free = !o_valid_r || out_ready;
  assign p_fire = p_valid_r && o_free;
  assign p_last = step_r == (plan_r.nres - 2'd1);
  assign p_end  = p_fire && p_last;

  assign take_ok = !p_valid_r || p_end;

  // current result of the held plan
  always_comb begin
    res.kind        = plan_r.kind;
    res.line_done   = plan_r.done;
    res.line_length = plan_r.len;
    res.last        = p_last;
    case (step_r)
      2'd0:    res.data = plan_r.b0;
      2'd1:    res.data = plan_r.b1;
      default: res.data = plan_r.b2;
    endcase
    if (plan_r.kind == KIND_READ) begin
      res.data = plan_r.hit ? rdata : 8'd0;
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    step_nxt    = step_r;
    if (p_fire) begin
      step_nxt = step_r + 2'd1;
    end
    if (p_end) begin
      p_valid_nxt = 1'b0;
    end
    if (accept) begin
      p_valid_nxt = plan_valid;
      step_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      step_r    <= 2'd0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      step_r    <= step_nxt;
      if (p_fire) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_r <= plan;
    end
    if (p_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = o_valid_r;
  assign out_item  = out_r;

endmodule

@@ hw/rtl/serial_line_editor_echo_unit.sv @@
// Serial line editor with echo. Each received character (opcode 0) edits the
// line held in an internal store and yields its echo bytes: backspace gives
// BS, space, BS (nothing on an empty line), CR gives CR LF, LF gives LF CR,
// a space in word mode gives itself and ends the word, any other byte is
// stored and echoed. A read (opcode 1) returns one stored byte, zero at or
// beyond the current length. An input's state update is done at the transfer
// and its results are queued in a plan register; results leave through a
// registered output stage at one per cycle while out_ready holds high. An
// item yields one result for a stored character, a terminator in word mode
// or a read, two for CR or LF, three for a backspace and none for an ignored
// backspace. The store needs no clearing pass after reset.
module serial_line_editor_echo_unit
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  plan_t      plan;
  logic       plan_valid;
  logic [7:0] rdata;
  logic       take_ok;
  logic       accept;

  // a new item may enter while the previous plan drains its last result
  assign in_ready = rst_n && take_ok;
  assign accept   = in_valid && in_ready;

  // line state, configuration and store
  sle_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .item       (in_item),
    .plan       (plan),
    .plan_valid (plan_valid),
    .rdata      (rdata)
  );

  // result sequencing and output register
  sle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan),
    .plan_valid (plan_valid),
    .accept     (accept),
    .rdata      (rdata),
    .take_ok    (take_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

@@ hw/rtl/sle_checker.sv @@
module sle_props
  import sle_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [DATA_W-1:0]    cfg_wdata,
  input logic                 in_valid,
  input logic                 in_ready,
  input in_item_t             in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_item_t            out_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // read data is a single result that never ends a line
  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_READ |-> out_item.last && !out_item.line_done)
    else $error("bad read result");

  // line length never reaches the full store
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.line_length != 8'd255)
    else $error("line length out of range");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind serial_line_editor_echo_unit sle_props u_chk (.*);

@@ tb/sle_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps a shadow of the line
// editor and scores every result transfer against the oldest prediction.
module sle_checker
  import sle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_item,
  output int unsigned          fail_count,
  output int unsigned          pending,
  output int unsigned          results_seen
);

  logic [7:0] line_buf [256];
  logic [7:0] held_len;
  logic       line_ended;
  logic [7:0] cap_reg;
  logic       word_on;
  out_item_t  results_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic void push_result(logic kind, logic [7:0] data, logic done, logic last);
    out_item_t r;
    r.kind        = kind;
    r.data        = data;
    r.line_done   = done;
    r.line_length = held_len;
    r.last        = last;
    results_due.push_back(r);
  endfunction

  // shadow of one input item: updates the line and queues its echo / read data
  function automatic void edit_line(in_item_t it);
    logic [7:0] limit;
    limit = (cap_reg < 8'd2) ? 8'd1 : cap_reg - 8'd1;
    if (it.opcode == OP_READ) begin
      push_result(KIND_READ, (it.read_index < held_len) ? line_buf[it.read_index] : 8'd0,
                  1'b0, 1'b1);
      return;
    end
    if (line_ended) begin
      held_len   = 8'd0;
      line_ended = 1'b0;
    end
    if (it.rx_char == CH_BS) begin
      if (held_len == 8'd0) return;  // nothing to erase, no echo
      held_len           = held_len - 8'd1;
      line_buf[held_len] = 8'd0;
      push_result(KIND_ECHO, CH_BS, 1'b0, 1'b0);
      push_result(KIND_ECHO, CH_SP, 1'b0, 1'b0);
      push_result(KIND_ECHO, CH_BS, 1'b0, 1'b1);
    end else if (it.rx_char == CH_CR) begin
      line_ended = 1'b1;
      push_result(KIND_ECHO, CH_CR, 1'b1, 1'b0);
      push_result(KIND_ECHO, CH_LF, 1'b1, 1'b1);
    end else if (it.rx_char == CH_LF) begin
      line_ended = 1'b1;
      push_result(KIND_ECHO, CH_LF, 1'b1, 1'b0);
      push_result(KIND_ECHO, CH_CR, 1'b1, 1'b1);
    end else if (word_on && it.rx_char == CH_SP) begin
      line_ended = 1'b1;
      push_result(KIND_ECHO, CH_SP, 1'b1, 1'b1);
    end else begin
      line_buf[held_len] = it.rx_char;
      held_len           = held_len + 8'd1;
      if (held_len >= limit) line_ended = 1'b1;
      push_result(KIND_ECHO, it.rx_char, line_ended, 1'b1);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) line_buf[i] = 8'd0;
      held_len   = 8'd0;
      line_ended = 1'b0;
      cap_reg    = CAP_RESET;
      word_on    = 1'b0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) cap_reg = cfg_wdata;
        else if (cfg_index == CFG_WORD_MODE) word_on = cfg_wdata[0];
      end
      // score first: a result leaving now never belongs to an item taken now
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d data %0d", out_item.kind, out_item.data);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("data", want.data, out_item.data);
          check_field("line_done", want.line_done, out_item.line_done);
          check_field("line_length", want.line_length, out_item.line_length);
          check_field("last", want.last, out_item.last);
        end
      end
      if (in_valid && in_ready) edit_line(in_item);
    end
    pending <= results_due.size();
  end

endmodule

@@ tb/tb_serial_line_editor_echo_unit.sv @@
`timescale 1ns / 100ps

// Line editor testbench: a directed pass over the edit rules, then random
// lines under several capacity / word-mode settings with random gaps on the
// input side and random back-pressure on the echo side. Scoring lives in
// sle_checker; this module only drives and gives the verdict.
module tb_serial_line_editor_echo_unit;
  import sle_pkg::*;

  localparam int QUIET_LIMIT = 500;  // cycles without any transfer
  localparam int ITEMS_PER_SETTING = 25;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;

  // run bookkeeping
  int unsigned items_sent = 0;
  int unsigned settings_run = 0;
  int unsigned quiet = 0;
  logic        no_idle = 1'b0;  // set for a burst phase: no gaps on either side
  int unsigned rx_stall = 0;
  int unsigned stall_left = 0;
  logic        word_now = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  serial_line_editor_echo_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  sle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Echo-side back-pressure: after each result transfer, ready may drop for a
  // randomly drawn stall, or stays up through a burst phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        rx_stall = no_idle ? 0 : $urandom_range(0, 9);
        if (rx_stall != 0) begin
          out_ready  <= 1'b0;
          stall_left <= rx_stall - 1;
        end
      end
    end else if (stall_left == 0) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input transfer. Valid is only dropped when a gap is drawn, so
  // back-to-back items keep it high with just the payload changing.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Unused field of each item carries random bits so every bit toggles.
  task automatic send_char(logic [7:0] ch);
    in_item_t it;
    it.opcode     = OP_CHAR;
    it.rx_char    = ch;
    it.read_index = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic send_read(logic [7:0] idx);
    in_item_t it;
    it.opcode     = OP_READ;
    it.rx_char    = 8'($urandom_range(0, 255));
    it.read_index = idx;
    send_item(it);
  endtask

  // Quiesce before a register write: drain every predicted result, then let
  // the clock run on with the input idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [7:0] cap, logic word);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_WORD_MODE, {{(DATA_W-1){1'b0}}, word});
    word_now = word;
    settings_run++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_BS || ch == CH_CR || ch == CH_LF || ch == CH_SP);
    return ch;
  endfunction

  // A typed line: characters with the odd correction or read-back mixed in,
  // closed by CR, LF, a space (a word end in word mode) or by capacity alone.
  task automatic send_line(int unsigned len);
    int unsigned pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_read(8'($urandom_range(0, len)));
      else if (pick == 1) send_char(CH_BS);
      else send_char(plain_char());
    end
    case ($urandom_range(0, 4))
      0, 1: send_char(CH_CR);
      2:    send_char(CH_LF);
      3:    send_char(CH_SP);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) send_read(8'($urandom_range(0, len)));
  endtask

  task automatic send_noise();
    in_item_t    it;
    logic [31:0] raw;
    raw = $urandom();
    it  = raw[$bits(in_item_t)-1:0];
    send_item(it);
  endtask

  initial begin
    logic [7:0] cap;
    logic       word;
    int unsigned stop_at;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset setting, capacity 255, line mode
    send_read(8'd0);      // empty line reads zero
    send_read(8'd255);
    send_char(CH_BS);     // backspace on empty line: no echo
    send_char("a");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_BS);     // erase 8'hFF
    send_read(8'd1);
    send_read(8'd2);      // at length: zero
    send_char(CH_SP);     // plain character in line mode
    send_char(CH_CR);
    send_read(8'd0);      // ended line is still readable
    send_char(CH_BS);     // starts a new, empty line; then ignored
    send_char(CH_LF);     // LF on empty line
    send_char("q");
    send_char(CH_LF);

    // word mode with a tiny store: space ends a word, capacity ends a line
    apply_setting(8'd4, 1'b1);
    send_char("h");
    send_char(CH_SP);
    send_char("a");
    send_char("b");
    send_char("c");       // third character hits capacity - 1
    send_read(8'd2);
    send_char("d");

    // capacity below two behaves as two
    apply_setting(8'd1, 1'b0);
    send_char("z");
    send_char("y");
    apply_setting(8'd0, 1'b1);
    send_char("w");

    // --- random: mostly well-formed lines, some raw noise
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cap = 8'd255; word = 1'b0; end
        1: begin cap = 8'd2;   word = 1'b1; end
        2: begin cap = 8'($urandom_range(3, 12)); word = 1'b0; end
        3: begin cap = 8'd255; word = 1'b1; end
        4: begin cap = 8'($urandom_range(2, 255)); word = 1'($urandom_range(0, 1)); end
        default: begin cap = 8'($urandom_range(3, 8)); word = 1'b1; end
      endcase
      apply_setting(cap, word);
      no_idle = (phase == 2);
      stop_at = items_sent + ITEMS_PER_SETTING;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_line($urandom_range(0, 8));
      end
    end
    no_idle = 1'b0;

    settle();
    $display("%0d items over %0d register settings, %0d results scored",
             items_sent, settings_run + 1, results_seen);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
